>>> hw/rtl/posp_pkg.sv
package posp_pkg;

    localparam int ADDR_BITS   = 16;
    localparam int STACK_DEPTH = 256;
    localparam int AW          = ADDR_BITS;
    localparam int SPW         = $clog2(STACK_DEPTH);
    localparam int MEM_DEPTH   = 1 << ADDR_BITS;

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_START = 2'd1,
        CMD_EXEC  = 2'd2,
        CMD_READ  = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_SYSCALL     = 3'd1,
        ST_HALTED      = 3'd2,
        ST_BAD_IMAGE   = 3'd3,
        ST_NOT_STARTED = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        RUN_OFF    = 2'd0,
        RUN_ACTIVE = 2'd1,
        RUN_HALTED = 2'd2
    } t_run;

    typedef enum logic [5:0] {
        OP_FETCH, OP_DUP, OP_CALL, OP_LIT, OP_DROP, OP_SWAP, OP_OVER, OP_NIP,
        OP_ROT, OP_TO_R, OP_COPY_R, OP_R_FETCH, OP_R_FROM, OP_RDROP, OP_RET, OP_JMP,
        OP_JT, OP_JF, OP_RET_T, OP_RET_F, OP_RET_TK, OP_RET_FK, OP_F_NZ, OP_F_ZERO,
        OP_F_EQ, OP_F_LT, OP_F_AND, OP_F_OR, OP_F_XOR, OP_F_NOT, OP_AND, OP_OR,
        OP_XOR, OP_NOT, OP_SHR, OP_SAR, OP_SHL, OP_ROL, OP_ADD, OP_SUB,
        OP_MUL, OP_DIV, OP_DIVMOD, OP_INC, OP_DEC, OP_ADD4, OP_SUB4, OP_SHL2,
        OP_ADD8, OP_TO_A, OP_A, OP_LD_A, OP_ST_A, OP_LD_AP4, OP_LDB_AP1, OP_ST_AP4,
        OP_STB_AP1, OP_LD, OP_ST, OP_LDH, OP_STH, OP_LDB, OP_STB, OP_SYS
    } t_op;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_MEM, S_MWAIT, S_POST, S_RT, S_RN, S_RX,
        S_EXE, S_DIVS, S_DIVW, S_WB, S_OUT
    } t_state;

    typedef enum logic [1:0] {
        SZ_BYTE, SZ_HALF, SZ_CELL
    } t_msz;

    typedef enum logic [2:0] {
        MK_LOAD, MK_READ, MK_START, MK_DATA, MK_FETCH
    } t_mk;

    typedef enum logic [1:0] {
        SRC_IMM, SRC_RES, SRC_REM
    } t_src;

    function automatic logic [31:0] swap32(input logic [31:0] v);
        return {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

    // flag stack: top is bit 31
    function automatic logic [31:0] fdrop(input logic [31:0] v);
        return {v[30:0], v[31]};
    endfunction

    function automatic logic [31:0] fpush(input logic [31:0] v, input logic c);
        return {c, v[31:1]};
    endfunction

endpackage

>>> hw/rtl/posp_div.sv
module posp_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_dividend,
    input  logic [31:0] i_divisor,
    output logic        o_done,
    output logic [31:0] o_quot,
    output logic [31:0] o_rem
);
    logic        r_run;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [31:0] r_q;
    logic [31:0] r_r;
    logic [31:0] r_d;
    logic [32:0] trial;
    logic        fits;

    // restoring, one quotient bit a cycle; a zero divisor yields all ones
    // and leaves the dividend as remainder
    assign trial = {r_r, r_q[31]};
    assign fits  = trial >= {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
                r_q   <= i_dividend;
                r_r   <= '0;
                r_d   <= i_divisor;
            end else if (r_run) begin
                r_q <= {r_q[30:0], fits};
                r_r <= fits ? 32'(trial - {1'b0, r_d}) : trial[31:0];
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_r;
endmodule

>>> hw/rtl/packed_opcode_stack_processor_unit.sv
// Two-stack processor over a byte memory, driven one command at a time. A command is taken
// when start is high and busy low; its single result appears for exactly one cycle with
// o_strobe and cannot be held off. After reset the byte memory is cleared one byte a cycle,
// so busy stays high until all 65536 bytes are clear. Command timing is set by the single-port
// byte memory (one byte a cycle) and the stack memories (one read a cycle, read data
// registered): an execute slot takes longer for each stack write, when it touches memory or
// refetches the instruction word, and for divide or divide-with-remainder (bit-serial unit).
module packed_opcode_stack_processor_unit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [1:0]            i_cmd,
    input  logic [15:0]           i_address,
    input  logic [31:0]           i_data,
    output logic                  o_strobe,
    output logic [2:0]            o_status,
    output logic [5:0]            o_syscall_code,
    output logic [31:0]           o_value_first,
    output logic [31:0]           o_value_second,
    output logic [31:0]           o_read_data
);
    import posp_pkg::*;

    localparam logic [5:0] SYS_EXIT   = 6'd0;
    localparam logic [5:0] SYS_SAVE   = 6'd1;
    localparam logic [5:0] SYS_EMIT   = 6'd16;
    localparam logic [5:0] SYS_WAIT   = 6'd17;
    localparam logic [5:0] SYS_COLOUR = 6'd18;
    localparam logic [5:0] SYS_MOVE   = 6'd19;

    t_state r_state, n_state;

    // architectural state
    logic [SPW-1:0] r_sp, r_rsp;
    logic [AW-1:0]  r_ip, r_a;
    logic [31:0]    r_latch, r_flag;
    logic           r_be;
    t_run           r_run;

    // memories
    logic [7:0]  main_mem [MEM_DEPTH];
    logic [31:0] ds_mem [STACK_DEPTH];
    logic [31:0] rs_mem [STACK_DEPTH];
    logic [7:0]  mm_q;
    logic [31:0] ds_q, rs_q;
    logic          mm_we;
    logic [AW-1:0] mm_addr;
    logic [7:0]    mm_wd;
    logic          ds_we, rs_we;
    logic [SPW-1:0] ds_wa, ds_ra, rs_wa;
    logic [31:0]   ds_wd, rs_wd;

    // byte engine
    logic [AW-1:0] r_clr;
    logic [AW-1:0] r_maddr;
    logic [1:0]    r_cnt, r_mlast;
    logic          r_mwr;
    logic [31:0]   r_mwd, r_mrd;
    t_msz          r_msz;
    t_mk           r_mkind;
    logic          r_fpush;
    logic          r_cap_v;
    logic [1:0]    r_cap_i;

    // per-slot working registers
    logic [31:0]   r_t, r_n, r_r, r_res, r_rem;
    logic          r_div;
    logic [1:0]    r_wn, r_wi;
    logic [SPW-1:0] r_wa [3];
    logic [31:0]   r_wd [3];
    t_src          r_ws [3];

    // result
    t_status       r_st;
    logic [5:0]    r_code;
    logic [31:0]   r_v1, r_v2, r_rd;

    // divider
    logic        div_start, div_done;
    logic [31:0] div_q, div_r;

    posp_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_n),
        .i_divisor  (r_t),
        .o_done     (div_done),
        .o_quot     (div_q),
        .o_rem      (div_r)
    );

    // ---------------- memories ----------------
    always_ff @(posedge i_clk) begin
        if (mm_we) begin
            main_mem[mm_addr] <= mm_wd;
        end
        mm_q <= main_mem[mm_addr];
    end

    always_ff @(posedge i_clk) begin
        if (ds_we) begin
            ds_mem[ds_wa] <= ds_wd;
        end
        ds_q <= ds_mem[ds_ra];
    end

    always_ff @(posedge i_clk) begin
        if (rs_we) begin
            rs_mem[rs_wa] <= rs_wd;
        end
        rs_q <= rs_mem[r_rsp];
    end

    // ---------------- slot decode ----------------
    t_op            op;
    logic [31:0]    lat_sh;
    logic [31:0]    x_w;
    logic           f_top;
    logic [4:0]     sh;
    logic [63:0]    rot_w;
    logic [5:0]     sys_code;
    logic [AW-1:0]  sv_ca;
    logic [32:0]    sv_sum;

    logic [SPW-1:0] e_nsp, e_nrsp;
    logic [31:0]    e_flag;
    logic [AW-1:0]  e_a, e_ip_tgt, e_maddr;
    logic           e_fetch, e_fpush, e_mem, e_mwr, e_div, e_rs_we;
    t_msz           e_msz;
    logic [31:0]    e_mwd, e_rs_wd;
    logic [SPW-1:0] e_rs_wa;
    logic [1:0]     e_wn;
    logic [SPW-1:0] e_wa [3];
    logic [31:0]    e_wd [3];
    t_src           e_ws [3];
    t_status        e_st;
    logic [5:0]     e_code;
    logic [31:0]    e_v1, e_v2;
    logic           e_halt;

    assign op       = t_op'(r_latch[5:0]);
    assign lat_sh   = {6'd0, r_latch[31:6]};
    assign x_w      = ds_q;
    assign f_top    = r_flag[31];
    assign sh       = r_t[4:0];
    assign rot_w    = {r_n, r_n} << sh;
    assign sys_code = r_t[5:0];
    assign sv_ca    = x_w[AW-1:0];
    assign sv_sum   = 33'(sv_ca) + {1'b0, r_n};

    always_comb begin
        e_nsp    = r_sp;
        e_nrsp   = r_rsp;
        e_flag   = r_flag;
        e_a      = r_a;
        e_ip_tgt = r_ip;
        e_fetch  = 1'b0;
        e_fpush  = 1'b0;
        e_mem    = 1'b0;
        e_mwr    = 1'b0;
        e_msz    = SZ_CELL;
        e_maddr  = r_a;
        e_mwd    = '0;
        e_div    = 1'b0;
        e_rs_we  = 1'b0;
        e_rs_wa  = r_rsp - SPW'(1);
        e_rs_wd  = r_t;
        e_wn     = 2'd0;
        for (int k = 0; k < 3; k++) begin
            e_wa[k] = r_sp;
            e_wd[k] = '0;
            e_ws[k] = SRC_IMM;
        end
        e_st   = ST_OK;
        e_code = '0;
        e_v1   = '0;
        e_v2   = '0;
        e_halt = 1'b0;

        unique case (op)
            OP_FETCH: e_fetch = 1'b1;
            OP_DUP: begin
                e_nsp = r_sp - SPW'(1); e_wn = 2'd1; e_wa[0] = e_nsp; e_wd[0] = r_t;
            end
            OP_CALL: begin
                e_rs_we = 1'b1; e_rs_wd = 32'(r_ip); e_nrsp = r_rsp - SPW'(1);
                e_ip_tgt = lat_sh[AW-1:0]; e_fetch = 1'b1;
            end
            OP_LIT: begin
                e_fetch = 1'b1; e_fpush = 1'b1;
                e_nsp = r_sp - SPW'(1); e_wn = 2'd1; e_wa[0] = e_nsp; e_ws[0] = SRC_RES;
            end
            OP_DROP: e_nsp = r_sp + SPW'(1);
            OP_SWAP: begin
                e_wn = 2'd2; e_wa[0] = r_sp + SPW'(1); e_wd[0] = r_t; e_wd[1] = r_n;
            end
            OP_OVER: begin
                e_nsp = r_sp - SPW'(1); e_wn = 2'd1; e_wa[0] = e_nsp; e_wd[0] = r_n;
            end
            OP_NIP: begin
                e_nsp = r_sp + SPW'(1); e_wn = 2'd1; e_wa[0] = e_nsp; e_wd[0] = r_t;
            end
            OP_ROT: begin
                e_wn = 2'd3; e_wd[0] = x_w;
                e_wa[1] = r_sp + SPW'(2); e_wd[1] = r_n;
                e_wa[2] = r_sp + SPW'(1); e_wd[2] = r_t;
            end
            OP_TO_R: begin
                e_rs_we = 1'b1; e_nrsp = r_rsp - SPW'(1); e_nsp = r_sp + SPW'(1);
            end
            OP_COPY_R: begin
                e_rs_we = 1'b1; e_nrsp = r_rsp - SPW'(1);
            end
            OP_R_FETCH: begin
                e_nsp = r_sp - SPW'(1); e_wn = 2'd1; e_wa[0] = e_nsp; e_wd[0] = r_r;
            end
            OP_R_FROM: begin
                e_nsp = r_sp - SPW'(1); e_wn = 2'd1; e_wa[0] = e_nsp; e_wd[0] = r_r;
                e_nrsp = r_rsp + SPW'(1);
            end
            OP_RDROP: e_nrsp = r_rsp + SPW'(1);
            OP_RET: begin
                e_ip_tgt = r_r[AW-1:0]; e_nrsp = r_rsp + SPW'(1); e_fetch = 1'b1;
            end
            OP_JMP: begin
                e_ip_tgt = lat_sh[AW-1:0]; e_fetch = 1'b1;
            end
            OP_JT, OP_JF: begin
                e_flag = fdrop(r_flag); e_fetch = 1'b1;
                if (f_top == (op == OP_JT)) begin
                    e_ip_tgt = lat_sh[AW-1:0];
                end
            end
            OP_RET_T, OP_RET_F: begin
                e_flag = fdrop(r_flag);
                if (f_top == (op == OP_RET_T)) begin
                    e_ip_tgt = r_r[AW-1:0]; e_nrsp = r_rsp + SPW'(1); e_fetch = 1'b1;
                end
            end
            OP_RET_TK, OP_RET_FK: begin
                if (f_top == (op == OP_RET_TK)) begin
                    e_ip_tgt = r_r[AW-1:0]; e_nrsp = r_rsp + SPW'(1); e_fetch = 1'b1;
                end else begin
                    e_flag = fdrop(r_flag);
                end
            end
            OP_F_NZ: e_flag = fpush(r_flag, r_t != '0);
            OP_F_ZERO: begin
                e_flag = fpush(r_flag, r_t == '0); e_nsp = r_sp + SPW'(1);
            end
            OP_F_EQ: begin
                e_flag = fpush(r_flag, r_n == r_t); e_nsp = r_sp + SPW'(2);
            end
            OP_F_LT: begin
                e_flag = fpush(r_flag, r_n < r_t); e_nsp = r_sp + SPW'(2);
            end
            OP_F_AND: e_flag = fpush(fdrop(fdrop(r_flag)), f_top & r_flag[30]);
            OP_F_OR:  e_flag = fpush(fdrop(fdrop(r_flag)), f_top | r_flag[30]);
            OP_F_XOR: e_flag = fpush(fdrop(fdrop(r_flag)), f_top ^ r_flag[30]);
            OP_F_NOT: e_flag = fpush(fdrop(r_flag), ~f_top);
            OP_AND, OP_OR, OP_XOR, OP_SHR, OP_SAR, OP_SHL, OP_ROL, OP_ADD, OP_SUB,
            OP_MUL: begin
                e_nsp = r_sp + SPW'(1); e_wn = 2'd1; e_wa[0] = e_nsp;
                unique case (op)
                    OP_AND:  e_wd[0] = r_n & r_t;
                    OP_OR:   e_wd[0] = r_n | r_t;
                    OP_XOR:  e_wd[0] = r_n ^ r_t;
                    OP_SHR:  e_wd[0] = r_n >> sh;
                    OP_SAR:  e_wd[0] = 32'($signed(r_n) >>> sh);
                    OP_SHL:  e_wd[0] = r_n << sh;
                    OP_ROL:  e_wd[0] = rot_w[63:32];
                    OP_ADD:  e_wd[0] = r_n + r_t;
                    OP_SUB:  e_wd[0] = r_n - r_t;
                    default: e_wd[0] = 32'(r_n * r_t);
                endcase
            end
            OP_NOT: begin
                e_wn = 2'd1; e_wd[0] = ~r_t;
            end
            OP_DIV: begin
                e_div = 1'b1; e_nsp = r_sp + SPW'(1);
                e_wn = 2'd1; e_wa[0] = e_nsp; e_ws[0] = SRC_RES;
            end
            OP_DIVMOD: begin
                e_div = 1'b1; e_wn = 2'd2;
                e_wa[0] = r_sp + SPW'(1); e_ws[0] = SRC_REM; e_ws[1] = SRC_RES;
            end
            OP_INC:  begin e_wn = 2'd1; e_wd[0] = r_t + 32'd1; end
            OP_DEC:  begin e_wn = 2'd1; e_wd[0] = r_t - 32'd1; end
            OP_ADD4: begin e_wn = 2'd1; e_wd[0] = r_t + 32'd4; end
            OP_SUB4: begin e_wn = 2'd1; e_wd[0] = r_t - 32'd4; end
            OP_SHL2: begin e_wn = 2'd1; e_wd[0] = r_t << 2; end
            OP_ADD8: begin e_wn = 2'd1; e_wd[0] = r_t + 32'd8; end
            OP_TO_A: begin
                e_a = r_t[AW-1:0]; e_nsp = r_sp + SPW'(1);
            end
            OP_A: begin
                e_nsp = r_sp - SPW'(1); e_wn = 2'd1; e_wa[0] = e_nsp; e_wd[0] = 32'(r_a);
            end
            OP_LD_A, OP_LD_AP4, OP_LDB_AP1: begin
                if (op == OP_LD_AP4) begin
                    e_a = r_a + AW'(4);
                end else if (op == OP_LDB_AP1) begin
                    e_a = r_a + AW'(1);
                end
                e_mem = 1'b1; e_maddr = e_a;
                e_msz = (op == OP_LDB_AP1) ? SZ_BYTE : SZ_CELL;
                e_nsp = r_sp - SPW'(1); e_wn = 2'd1; e_wa[0] = e_nsp; e_ws[0] = SRC_RES;
            end
            OP_ST_A, OP_ST_AP4, OP_STB_AP1: begin
                if (op == OP_ST_AP4) begin
                    e_a = r_a + AW'(4);
                end else if (op == OP_STB_AP1) begin
                    e_a = r_a + AW'(1);
                end
                e_mem = 1'b1; e_mwr = 1'b1; e_maddr = e_a;
                e_msz = (op == OP_STB_AP1) ? SZ_BYTE : SZ_CELL;
                e_mwd = (op != OP_STB_AP1 && r_be) ? swap32(r_t) : r_t;
                e_nsp = r_sp + SPW'(1);
            end
            OP_LD, OP_LDH, OP_LDB: begin
                e_mem = 1'b1; e_maddr = r_t[AW-1:0];
                e_msz = (op == OP_LD) ? SZ_CELL : (op == OP_LDH) ? SZ_HALF : SZ_BYTE;
                e_wn = 2'd1; e_ws[0] = SRC_RES;
            end
            OP_ST, OP_STH, OP_STB: begin
                e_mem = 1'b1; e_mwr = 1'b1; e_maddr = r_t[AW-1:0];
                e_nsp = r_sp + SPW'(2);
                if (op == OP_ST) begin
                    e_msz = SZ_CELL; e_mwd = r_be ? swap32(r_n) : r_n;
                end else if (op == OP_STH) begin
                    e_msz = SZ_HALF;
                    e_mwd = r_be ? {16'd0, r_n[7:0], r_n[15:8]} : r_n;
                end else begin
                    e_msz = SZ_BYTE; e_mwd = r_n;
                end
            end
            OP_SYS: begin
                e_code = sys_code;
                e_st   = ST_SYSCALL;
                e_nsp  = r_sp + SPW'(1);
                if (sys_code == SYS_EXIT) begin
                    e_v1 = r_n; e_st = ST_HALTED; e_halt = 1'b1;
                end else if (sys_code == SYS_SAVE) begin
                    e_nsp = r_sp + SPW'(3);
                    e_v1  = 32'(sv_ca);
                    e_v2  = (sv_sum > 33'(MEM_DEPTH)) ? 32'(MEM_DEPTH) - 32'(sv_ca) : r_n;
                end else if (sys_code == SYS_EMIT || sys_code == SYS_COLOUR ||
                             sys_code == SYS_MOVE) begin
                    e_v1 = r_n; e_nsp = r_sp + SPW'(2);
                end else if (sys_code == SYS_WAIT) begin
                    e_v1 = r_n; e_nsp = r_sp + SPW'(2); e_flag = fpush(r_flag, 1'b0);
                end
            end
            default: e_fetch = 1'b0;
        endcase

        if (e_fetch) begin
            e_maddr = e_ip_tgt;
            e_msz   = SZ_CELL;
        end
    end

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    unique case (t_cmd'(i_cmd))
                        CMD_LOAD, CMD_READ, CMD_START: n_state = S_MEM;
                        CMD_EXEC: n_state = (r_run == RUN_ACTIVE) ? S_RT : S_OUT;
                        default: n_state = S_OUT;
                    endcase
                end
            end
            S_MEM: begin
                if (r_cnt == r_mlast) begin
                    n_state = S_MWAIT;
                end
            end
            S_MWAIT: n_state = S_POST;
            S_POST: begin
                if (r_mkind == MK_DATA || r_mkind == MK_FETCH) begin
                    n_state = (r_wn != 2'd0) ? S_WB : S_OUT;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_RT: n_state = S_RN;
            S_RN: n_state = S_RX;
            S_RX: n_state = S_EXE;
            S_EXE: begin
                if (e_mem || e_fetch) begin
                    n_state = S_MEM;
                end else if (e_div) begin
                    n_state = S_DIVS;
                end else if (e_wn != 2'd0) begin
                    n_state = S_WB;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_DIVS: n_state = S_DIVW;
            S_DIVW: begin
                if (div_done) begin
                    n_state = S_WB;
                end
            end
            S_WB: begin
                if (r_wi == r_wn - 2'd1) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // memory port steering
    always_comb begin
        mm_we   = 1'b0;
        mm_addr = r_maddr + AW'(r_cnt);
        mm_wd   = r_mwd[8*r_cnt +: 8];
        if (r_state == S_CLEAR) begin
            mm_we   = 1'b1;
            mm_addr = r_clr;
            mm_wd   = '0;
        end else if (r_state == S_MEM) begin
            mm_we = r_mwr;
        end
    end

    always_comb begin
        unique case (r_state)
            S_RN:    ds_ra = r_sp + SPW'(1);
            S_RX:    ds_ra = r_sp + SPW'(2);
            default: ds_ra = r_sp;
        endcase
    end

    assign ds_we = (r_state == S_WB);
    assign ds_wa = r_wa[r_wi];
    always_comb begin
        unique case (r_ws[r_wi])
            SRC_RES: ds_wd = r_res;
            SRC_REM: ds_wd = r_rem;
            default: ds_wd = r_wd[r_wi];
        endcase
    end

    assign rs_we     = (r_state == S_EXE) && e_rs_we;
    assign rs_wa     = e_rs_wa;
    assign rs_wd     = e_rs_wd;
    assign div_start = (r_state == S_DIVS);

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr   <= '0;
            r_cnt   <= '0;
            r_cap_v <= 1'b0;
            r_sp    <= '0;
            r_rsp   <= '0;
            r_ip    <= '0;
            r_latch <= '0;
            r_flag  <= '0;
            r_a     <= '0;
            r_be    <= 1'b0;
            r_run   <= RUN_OFF;
        end else begin
            r_cap_v <= (r_state == S_MEM) && !r_mwr;
            unique case (r_state)
                S_CLEAR: r_clr <= r_clr + AW'(1);
                S_IDLE: begin
                    r_cnt <= '0;
                    if (start && t_cmd'(i_cmd) == CMD_START) begin
                        r_sp   <= '0;
                        r_rsp  <= '0;
                        r_flag <= '0;
                        r_a    <= '0;
                        r_be   <= 1'b0;
                        r_ip   <= AW'(4);
                    end
                end
                S_MEM: r_cnt <= r_cnt + 2'd1;
                S_POST: begin
                    if (r_mkind == MK_START) begin
                        if (r_mrd[29:24] == 6'd15) begin
                            r_latch <= swap32(r_mrd);
                            r_be    <= 1'b1;
                            r_run   <= RUN_ACTIVE;
                        end else begin
                            r_latch <= r_mrd;
                            r_run   <= (r_mrd[5:0] == 6'd15) ? RUN_ACTIVE : RUN_OFF;
                        end
                    end else if (r_mkind == MK_FETCH && !r_fpush) begin
                        r_latch <= r_be ? swap32(r_mrd) : r_mrd;
                    end
                end
                S_EXE: begin
                    r_sp    <= e_nsp;
                    r_rsp   <= e_nrsp;
                    r_flag  <= e_flag;
                    r_a     <= e_a;
                    r_latch <= lat_sh;
                    if (e_fetch) begin
                        r_ip <= e_ip_tgt + AW'(4);
                    end
                    if (e_halt) begin
                        r_run <= RUN_HALTED;
                    end
                end
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (r_cap_v) begin
            r_mrd[8*r_cap_i +: 8] <= mm_q;
        end
        r_cap_i <= r_cnt;

        unique case (r_state)
            S_IDLE: begin
                r_st   <= ST_OK;
                r_code <= '0;
                r_v1   <= '0;
                r_v2   <= '0;
                r_rd   <= '0;
                r_wn   <= '0;
                r_wi   <= '0;
                r_div  <= 1'b0;
                r_maddr <= i_address[AW-1:0];
                r_mwd   <= i_data;
                r_mwr   <= (t_cmd'(i_cmd) == CMD_LOAD);
                r_mlast <= 2'd3;
                r_msz   <= SZ_CELL;
                r_fpush <= 1'b0;
                unique case (t_cmd'(i_cmd))
                    CMD_LOAD:  r_mkind <= MK_LOAD;
                    CMD_READ:  r_mkind <= MK_READ;
                    CMD_START: begin
                        r_mkind <= MK_START;
                        r_maddr <= '0;
                    end
                    default: begin
                        r_mkind <= MK_DATA;
                        r_st <= (r_run == RUN_OFF) ? ST_NOT_STARTED : ST_HALTED;
                    end
                endcase
            end
            S_RN: begin
                r_t <= ds_q;
                r_r <= rs_q;
            end
            S_RX: r_n <= ds_q;
            S_EXE: begin
                r_st    <= e_st;
                r_code  <= e_code;
                r_v1    <= e_v1;
                r_v2    <= e_v2;
                r_div   <= e_div;
                r_wn    <= e_wn;
                r_wa    <= e_wa;
                r_wd    <= e_wd;
                r_ws    <= e_ws;
                r_maddr <= e_maddr;
                r_mwr   <= e_mwr;
                r_mwd   <= e_mwd;
                r_msz   <= e_msz;
                r_fpush <= e_fpush;
                r_mkind <= e_fetch ? MK_FETCH : MK_DATA;
                unique case (e_msz)
                    SZ_BYTE: r_mlast <= 2'd0;
                    SZ_HALF: r_mlast <= 2'd1;
                    default: r_mlast <= 2'd3;
                endcase
            end
            S_POST: begin
                unique case (r_mkind)
                    MK_READ:  r_rd <= r_mrd;
                    MK_START: begin
                        if (r_mrd[29:24] != 6'd15 && r_mrd[5:0] != 6'd15) begin
                            r_st <= ST_BAD_IMAGE;
                        end
                    end
                    MK_FETCH: r_res <= r_be ? swap32(r_mrd) : r_mrd;
                    MK_DATA: begin
                        unique case (r_msz)
                            SZ_BYTE: r_res <= {24'd0, r_mrd[7:0]};
                            SZ_HALF: r_res <= r_be ? {16'd0, r_mrd[7:0], r_mrd[15:8]}
                                                   : {16'd0, r_mrd[15:0]};
                            default: r_res <= r_be ? swap32(r_mrd) : r_mrd;
                        endcase
                    end
                    default: r_res <= r_res;
                endcase
            end
            S_DIVW: begin
                if (div_done) begin
                    r_res <= div_q;
                    r_rem <= div_r;
                end
            end
            S_WB: r_wi <= r_wi + 2'd1;
            default: r_wi <= r_wi;
        endcase
    end

    assign busy           = (r_state != S_IDLE);
    assign o_strobe       = (r_state == S_OUT);
    assign o_status       = r_st;
    assign o_syscall_code = r_code;
    assign o_value_first  = r_v1;
    assign o_value_second = r_v2;
    assign o_read_data    = r_rd;

endmodule

>>> hw/rtl/posp_checker.sv
module posp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_strobe,
    input logic [2:0]  o_status,
    input logic [5:0]  o_syscall_code,
    input logic [31:0] o_value_second,
    input logic [31:0] o_read_data
);
    import posp_pkg::*;

    // a taken command keeps the block busy until its result
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("command taken but block not busy");

    // results only come while busy, and the block frees right after
    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (busy ##1 !busy))
        else $error("result strobe outside a command");

    // single cycle strobe
    a_strobe_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("strobe longer than one cycle");

    // syscall code only with a syscall or exit report
    a_code_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status != ST_SYSCALL && o_status != ST_HALTED)
            |-> (o_syscall_code == '0 && o_value_second == '0))
        else $error("stray syscall fields");

    // read data only from a successful read
    a_read_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status != ST_OK) |-> (o_read_data == '0))
        else $error("read data with non-ok status");

endmodule

bind packed_opcode_stack_processor_unit posp_checker u_posp_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_strobe       (o_strobe),
    .o_status       (o_status),
    .o_syscall_code (o_syscall_code),
    .o_value_second (o_value_second),
    .o_read_data    (o_read_data)
);

>>> verif/testbench.sv
`timescale 1ns / 1ps

import posp_pkg::*;

// syscall numbers that carry values to the host
localparam logic [5:0] SYS_EXIT   = 6'd0;
localparam logic [5:0] SYS_SAVE   = 6'd1;
localparam logic [5:0] SYS_EMIT   = 6'd16;
localparam logic [5:0] SYS_WAIT   = 6'd17;
localparam logic [5:0] SYS_COLOUR = 6'd18;
localparam logic [5:0] SYS_MOVE   = 6'd19;

// Shadow copy of the processor: predicts each command's result and checks what comes out.
class opstack_scoreboard;
    typedef struct {
        logic [2:0]  status;
        logic [5:0]  code;
        logic [31:0] first;
        logic [31:0] second;
        logic [31:0] rdata;
    } result_t;

    result_t     pending[$];
    int          errors;
    logic [7:0]  mem[0:65535];
    logic [31:0] dstk[0:255];
    logic [31:0] rstk[0:255];
    bit          dok[0:255];
    bit          rok[0:255];
    logic [7:0]  dsp, rsp;
    logic [15:0] ip, areg;
    logic [31:0] latch, flags;
    bit          big;
    t_run        run;

    function new();
        foreach (mem[i]) mem[i] = 8'h00;
        foreach (dstk[i]) begin
            dstk[i] = '0; rstk[i] = '0; dok[i] = 0; rok[i] = 0;
        end
        dsp = 0; rsp = 0; ip = 0; areg = 0; latch = 0; flags = 0; big = 0;
        run = RUN_OFF; errors = 0;
    endfunction

    function logic [31:0] bswap(logic [31:0] v);
        return {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

    function logic [31:0] rdb(logic [15:0] a);
        return {24'd0, mem[a]};
    endfunction

    function logic [31:0] rd_le(logic [15:0] a);
        return {mem[a + 16'd3], mem[a + 16'd2], mem[a + 16'd1], mem[a]};
    endfunction

    function void wr_le(logic [15:0] a, logic [31:0] v);
        for (int i = 0; i < 4; i++) mem[a + 16'(i)] = v[8*i +: 8];
    endfunction

    function logic [31:0] rd_cell(logic [15:0] a);
        return big ? bswap(rd_le(a)) : rd_le(a);
    endfunction

    function void wr_cell(logic [15:0] a, logic [31:0] v);
        wr_le(a, big ? bswap(v) : v);
    endfunction

    function logic [31:0] rd_half(logic [15:0] a);
        return big ? {16'd0, mem[a], mem[a + 16'd1]} : {16'd0, mem[a + 16'd1], mem[a]};
    endfunction

    function void wr_half(logic [15:0] a, logic [31:0] v);
        if (big) begin
            mem[a] = v[15:8]; mem[a + 16'd1] = v[7:0];
        end else begin
            mem[a] = v[7:0]; mem[a + 16'd1] = v[15:8];
        end
    endfunction

    function logic [31:0] dget(int k);
        return dstk[8'(dsp + k)];
    endfunction

    function void dset(int k, logic [31:0] v);
        dstk[8'(dsp + k)] = v;
        dok[8'(dsp + k)] = 1;
    endfunction

    function void dpush(logic [31:0] v);
        dsp = dsp - 8'd1;
        dset(0, v);
    endfunction

    function logic [31:0] dpop();
        logic [31:0] v;
        v = dget(0);
        dsp = dsp + 8'd1;
        return v;
    endfunction

    function void rpush(logic [31:0] v);
        rsp = rsp - 8'd1;
        rstk[rsp] = v;
        rok[rsp] = 1;
    endfunction

    function logic [31:0] rpop();
        logic [31:0] v;
        v = rstk[rsp];
        rsp = rsp + 8'd1;
        return v;
    endfunction

    function logic [31:0] fetch_cell();
        logic [31:0] v;
        v = rd_cell(ip);
        ip = ip + 16'd4;
        return v;
    endfunction

    function void jump(logic [31:0] a);
        ip = a[15:0];
        latch = fetch_cell();
    endfunction

    function logic fpop();
        logic f;
        f = flags[31];
        flags = {flags[30:0], flags[31]};
        return f;
    endfunction

    function void fpush(logic c);
        flags = {c, flags[31:1]};
    endfunction

    function void binop(logic [31:0] v);
        dset(1, v);
        dsp = dsp + 8'd1;
    endfunction

    // True when the next slot only reads stack entries that have been written.
    function bit slot_safe();
        t_op op;
        int  dn, rn;
        op = t_op'(latch[5:0]);
        dn = 0; rn = 0;
        if (run != RUN_ACTIVE) return 1;
        if (op == OP_ROT) dn = 3;
        else if (op inside {OP_SWAP, OP_OVER, OP_NIP, OP_F_EQ, OP_F_LT, OP_ST, OP_STH, OP_STB}
                 || (op >= OP_AND && op <= OP_DIVMOD)) dn = 2;
        else if (op inside {OP_DUP, OP_TO_R, OP_COPY_R, OP_F_NZ, OP_F_ZERO, OP_ST_A,
                            OP_ST_AP4, OP_STB_AP1, OP_LD, OP_LDH, OP_LDB}
                 || (op >= OP_INC && op <= OP_TO_A)) dn = 1;
        else if (op == OP_SYS) begin
            if (!dok[dsp]) return 0;
            case (dget(0) & 32'h3f)
                SYS_EXIT, SYS_EMIT, SYS_WAIT, SYS_COLOUR, SYS_MOVE: dn = 2;
                SYS_SAVE: dn = 3;
                default: dn = 1;
            endcase
        end
        if (op == OP_R_FETCH || op == OP_R_FROM || op == OP_RET
            || (op >= OP_RET_T && op <= OP_RET_FK)) rn = 1;
        for (int k = 0; k < dn; k++) if (!dok[8'(dsp + k)]) return 0;
        if (rn > 0 && !rok[rsp]) return 0;
        return 1;
    endfunction

    function void do_slot(ref result_t r);
        t_op         op;
        logic [31:0] t, n, x, len, ca;
        logic [4:0]  s;
        op = t_op'(latch[5:0]);
        latch = latch >> 6;
        t = dget(0);
        n = dget(1);
        s = t[4:0];
        case (op)
            OP_FETCH:    latch = fetch_cell();
            OP_DUP:      dpush(t);
            OP_CALL: begin rpush({16'd0, ip}); jump(latch); end
            OP_LIT:      dpush(fetch_cell());
            OP_DROP:     dsp = dsp + 8'd1;
            OP_SWAP: begin dset(1, t); dset(0, n); end
            OP_OVER:     dpush(n);
            OP_NIP:      binop(t);
            OP_ROT: begin dset(0, dget(2)); dset(2, n); dset(1, t); end
            OP_TO_R:     rpush(dpop());
            OP_COPY_R:   rpush(t);
            OP_R_FETCH:  dpush(rstk[rsp]);
            OP_R_FROM:   dpush(rpop());
            OP_RDROP:    rsp = rsp + 8'd1;
            OP_RET:      jump(rpop());
            OP_JMP:      jump(latch);
            OP_JT:       if (fpop()) jump(latch); else latch = fetch_cell();
            OP_JF:       if (!fpop()) jump(latch); else latch = fetch_cell();
            OP_RET_T:    if (fpop()) jump(rpop());
            OP_RET_F:    if (!fpop()) jump(rpop());
            OP_RET_TK:   if (flags[31]) jump(rpop()); else void'(fpop());
            OP_RET_FK:   if (!flags[31]) jump(rpop()); else void'(fpop());
            OP_F_NZ:     fpush(t != 0);
            OP_F_ZERO: begin fpush(t == 0); dsp = dsp + 8'd1; end
            OP_F_EQ: begin fpush(n == t); dsp = dsp + 8'd2; end
            OP_F_LT: begin fpush(n < t); dsp = dsp + 8'd2; end
            OP_F_AND: begin x = fpop(); fpush(x[0] & fpop()); end
            OP_F_OR: begin x = fpop(); fpush(x[0] | fpop()); end
            OP_F_XOR: begin x = fpop(); fpush(x[0] ^ fpop()); end
            OP_F_NOT:    fpush(!fpop());
            OP_AND:      binop(n & t);
            OP_OR:       binop(n | t);
            OP_XOR:      binop(n ^ t);
            OP_NOT:      dset(0, ~t);
            OP_SHR:      binop(n >> s);
            OP_SAR:      binop($unsigned($signed(n) >>> s));
            OP_SHL:      binop(n << s);
            OP_ROL:      binop(s != 0 ? ((n << s) | (n >> (6'd32 - s))) : n);
            OP_ADD:      binop(n + t);
            OP_SUB:      binop(n - t);
            OP_MUL:      binop(n * t);
            OP_DIV:      binop(t != 0 ? n / t : 32'hffff_ffff);
            OP_DIVMOD: begin
                dset(1, t != 0 ? n % t : n);
                dset(0, t != 0 ? n / t : 32'hffff_ffff);
            end
            OP_INC:      dset(0, t + 1);
            OP_DEC:      dset(0, t - 1);
            OP_ADD4:     dset(0, t + 4);
            OP_SUB4:     dset(0, t - 4);
            OP_SHL2:     dset(0, t << 2);
            OP_ADD8:     dset(0, t + 8);
            OP_TO_A: begin areg = t[15:0]; dsp = dsp + 8'd1; end
            OP_A:        dpush({16'd0, areg});
            OP_LD_A:     dpush(rd_cell(areg));
            OP_ST_A: begin wr_cell(areg, t); dsp = dsp + 8'd1; end
            OP_LD_AP4: begin areg = areg + 16'd4; dpush(rd_cell(areg)); end
            OP_LDB_AP1: begin areg = areg + 16'd1; dpush(rdb(areg)); end
            OP_ST_AP4: begin areg = areg + 16'd4; wr_cell(areg, t); dsp = dsp + 8'd1; end
            OP_STB_AP1: begin areg = areg + 16'd1; mem[areg] = t[7:0]; dsp = dsp + 8'd1; end
            OP_LD:       dset(0, rd_cell(t[15:0]));
            OP_ST: begin wr_cell(t[15:0], n); dsp = dsp + 8'd2; end
            OP_LDH:      dset(0, rd_half(t[15:0]));
            OP_STH: begin wr_half(t[15:0], n); dsp = dsp + 8'd2; end
            OP_LDB:      dset(0, rdb(t[15:0]));
            OP_STB: begin mem[t[15:0]] = n[7:0]; dsp = dsp + 8'd2; end
            default: begin
                // host syscall: the code is popped first
                r.code = t[5:0];
                dsp = dsp + 8'd1;
                r.status = ST_SYSCALL;
                case (t[5:0])
                    SYS_EXIT: begin
                        r.first = dget(0); r.status = ST_HALTED; run = RUN_HALTED;
                    end
                    SYS_SAVE: begin
                        len = dpop();
                        ca = dpop() & 32'hffff;
                        if (33'(ca) + 33'(len) > 33'h10000) len = 32'h10000 - ca;
                        r.first = ca; r.second = len;
                    end
                    SYS_EMIT, SYS_COLOUR, SYS_MOVE: r.first = dpop();
                    SYS_WAIT: begin r.first = dpop(); fpush(0); end
                    default: ;
                endcase
            end
        endcase
    endfunction

    // An accepted command: update the shadow state and queue what it must produce.
    function void note_transfer(t_cmd c, logic [15:0] a, logic [31:0] d);
        result_t r;
        r = '{ST_OK, 6'd0, 32'd0, 32'd0, 32'd0};
        case (c)
            CMD_LOAD:  for (int i = 0; i < 4; i++) mem[a + 16'(i)] = d[8*i +: 8];
            CMD_READ:  r.rdata = rd_le(a);
            CMD_START: begin
                dsp = 0; rsp = 0; flags = 0; areg = 0; big = 0;
                latch = rd_le(16'd0);
                ip = 16'd4;
                if ((latch & 32'h3f00_0000) == 32'h0f00_0000) begin
                    latch = bswap(latch); big = 1; run = RUN_ACTIVE;
                end else if ((latch & 32'h0000_003f) != 32'h0000_000f) begin
                    run = RUN_OFF; r.status = ST_BAD_IMAGE;
                end else begin
                    run = RUN_ACTIVE;
                end
            end
            default: begin
                if (run == RUN_OFF) r.status = ST_NOT_STARTED;
                else if (run == RUN_HALTED) r.status = ST_HALTED;
                else do_slot(r);
            end
        endcase
        pending.push_back(r);
    endfunction

    function void check_result(logic [2:0] st, logic [5:0] code, logic [31:0] v1,
                               logic [31:0] v2, logic [31:0] rd);
        result_t e;
        if (pending.size() == 0) begin
            $error("result with nothing outstanding: status %0d", st);
            errors++;
            return;
        end
        e = pending.pop_front();
        if (st !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, st); errors++;
        end
        if (code !== e.code) begin
            $error("syscall_code: expected %0d, got %0d", e.code, code); errors++;
        end
        if (v1 !== e.first) begin
            $error("value_first: expected %h, got %h", e.first, v1); errors++;
        end
        if (v2 !== e.second) begin
            $error("value_second: expected %h, got %h", e.second, v2); errors++;
        end
        if (rd !== e.rdata) begin
            $error("read_data: expected %h, got %h", e.rdata, rd); errors++;
        end
    endfunction
endclass

module testbench;
    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_cmd;
    logic [15:0] i_address;
    logic [31:0] i_data;
    logic        o_strobe;
    logic [2:0]  o_status;
    logic [5:0]  o_syscall_code;
    logic [31:0] o_value_first;
    logic [31:0] o_value_second;
    logic [31:0] o_read_data;

    opstack_scoreboard shadow = new();
    int  n_items;
    bit  no_gaps;

    packed_opcode_stack_processor_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_cmd          (i_cmd),
        .i_address      (i_address),
        .i_data         (i_data),
        .o_strobe       (o_strobe),
        .o_status       (o_status),
        .o_syscall_code (o_syscall_code),
        .o_value_first  (o_value_first),
        .o_value_second (o_value_second),
        .o_read_data    (o_read_data)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // Results cannot be held off, so every strobe is checked at the edge that ends it.
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe)
            shadow.check_result(o_status, o_syscall_code, o_value_first,
                                o_value_second, o_read_data);
    end

    // One command transfer. Inputs move on the falling edge; start is left high after
    // acceptance so a back-to-back transfer never drops and re-raises it in one step.
    task automatic transfer(t_cmd c, logic [15:0] a, logic [31:0] d);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 9);
        repeat (gap) begin
            @(negedge i_clk);
            start = 1'b0;
        end
        @(negedge i_clk);
        start     = 1'b1;
        i_cmd     = c;
        i_address = a;
        i_data    = d;
        do @(posedge i_clk); while (busy);
        shadow.note_transfer(c, a, d);
        n_items++;
    endtask

    function automatic logic [31:0] pack_ops(t_op o0, t_op o1, t_op o2, t_op o3, t_op o4);
        return {2'b00, o4, o3, o2, o1, o0};
    endfunction

    // Program words: mostly five random opcodes (the two spare bits force a fetch),
    // sometimes a literal that lands on a syscall number or an extreme value.
    function automatic logic [31:0] program_word();
        logic [31:0] w;
        w = 0;
        if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 8))
                0: w = SYS_EXIT;
                1: w = SYS_SAVE;
                2: w = SYS_EMIT;
                3: w = SYS_WAIT;
                4: w = SYS_COLOUR;
                5: w = SYS_MOVE;
                6: w = 32'hffff_ffff;
                7: w = 32'h8000_0000;
                default: w = $urandom_range(0, 63);
            endcase
        end else begin
            for (int i = 0; i < 5; i++) w[6*i +: 6] = $urandom_range(0, 63);
        end
        return w;
    endfunction

    // Fresh image: header at 0 jumping to a small program, then start.
    task automatic new_image();
        logic [15:0] entry;
        logic [31:0] hdr;
        entry = 16'd64 + 16'($urandom_range(0, 200) * 4);
        hdr   = {10'd0, entry, 6'd15};
        case ($urandom_range(0, 9))
            0:       hdr = $urandom;
            1, 2, 3: hdr = shadow.bswap(hdr);
            default: ;
        endcase
        transfer(CMD_LOAD, 16'd0, hdr);
        for (int i = 0; i < 10; i++)
            transfer(CMD_LOAD, entry + 16'(4 * i), program_word());
        transfer(CMD_START, 16'($urandom), $urandom);
    endtask

    initial begin
        int slots_left;
        start     = 1'b0;
        i_cmd     = CMD_LOAD;
        i_address = '0;
        i_data    = '0;
        i_rst_n   = 1'b0;
        n_items   = 0;
        no_gaps   = 0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: commands before start, wrapping load and read, empty image
        transfer(CMD_EXEC, 16'hffff, 32'hffff_ffff);
        transfer(CMD_LOAD, 16'hffff, 32'ha5c3_0ff0);
        transfer(CMD_READ, 16'hfffe, 32'h0);
        transfer(CMD_START, 16'h0, 32'h0);
        transfer(CMD_LOAD, 16'h0, 32'h0);
        transfer(CMD_START, 16'h0, 32'h0);

        // directed program: divide by zero, divide with remainder, arithmetic shift,
        // emit, save clipped at the memory end, exit
        transfer(CMD_LOAD, 16'd0, {10'd0, 16'd64, 6'd15});
        transfer(CMD_LOAD, 16'd64, pack_ops(OP_LIT, OP_LIT, OP_DIV, OP_LIT, OP_DIVMOD));
        transfer(CMD_LOAD, 16'd68, 32'h8000_0000);
        transfer(CMD_LOAD, 16'd72, 32'h0);
        transfer(CMD_LOAD, 16'd76, 32'd5);
        transfer(CMD_LOAD, 16'd80, pack_ops(OP_LIT, OP_SAR, OP_LIT, OP_SYS, OP_LIT));
        transfer(CMD_LOAD, 16'd84, 32'd33);
        transfer(CMD_LOAD, 16'd88, {26'd0, SYS_EMIT});
        transfer(CMD_LOAD, 16'd92, 32'h0000_fff0);
        transfer(CMD_LOAD, 16'd96, pack_ops(OP_LIT, OP_LIT, OP_SYS, OP_LIT, OP_SYS));
        transfer(CMD_LOAD, 16'd100, 32'd100);
        transfer(CMD_LOAD, 16'd104, {26'd0, SYS_SAVE});
        transfer(CMD_LOAD, 16'd108, {26'd0, SYS_EXIT});
        transfer(CMD_START, 16'h0, 32'h0);
        for (int i = 0; i < 20 && shadow.run == RUN_ACTIVE && shadow.slot_safe(); i++)
            transfer(CMD_EXEC, 16'h0, 32'h0);
        transfer(CMD_EXEC, 16'h0, 32'h0);

        // random: short programs, restarted when they halt, run out or would read
        // a stack entry that was never written; loads and reads mixed in
        slots_left = 0;
        while (n_items < 850) begin
            if ($urandom_range(0, 49) == 0) no_gaps = !no_gaps;
            if (shadow.run != RUN_ACTIVE || slots_left == 0 || !shadow.slot_safe()) begin
                new_image();
                slots_left = $urandom_range(15, 60);
            end else begin
                case ($urandom_range(0, 24))
                    0, 1: transfer(CMD_LOAD, 16'($urandom), $urandom);
                    2:    transfer(CMD_READ, 16'($urandom), $urandom);
                    default: begin
                        transfer(CMD_EXEC, 16'($urandom), $urandom);
                        slots_left--;
                    end
                endcase
            end
        end

        @(negedge i_clk);
        start = 1'b0;
        while (shadow.pending.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (shadow.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // covers the memory clear after reset plus the slowest commands with full gaps
    initial begin
        #3_000_000;
        $display("Test completed with failures");
        $finish;
    end
endmodule
